[rtl/core/fru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_pkg
// Types and fixed-point constants shared by the Fresnel reflectance unit.
// ----------------------------------------------------------------------------
package fru_pkg;

    // Fixed-point formats: index Q3.12, cosines and results Q1.16, work Q.16.
    localparam int INDEX_FRAC_BITS = 12;
    localparam int COS_FRAC_BITS   = 16;
    localparam int WORK_BITS       = 16;
    localparam int IDX_SHIFT       = WORK_BITS - INDEX_FRAC_BITS;

    localparam int IDX_W  = 16;
    localparam int FRAC_W = 17;
    localparam int NW_W   = IDX_W - 1 + IDX_SHIFT;

    localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << COS_FRAC_BITS;

    typedef struct packed {
        logic signed [IDX_W-1:0]  rel_index;
        logic        [FRAC_W-1:0] cos_incidence;
    } t_in_beat;

    typedef struct packed {
        logic [FRAC_W-1:0] reflectance;
        logic [FRAC_W-1:0] transmittance;
        logic              total_reflection;
    } t_out_beat;

endpackage

[rtl/core/fresnel_reflectance_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_reflectance_unit
// Unpolarised Fresnel reflectance and transmittance of a dielectric boundary.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Depth is set by the two square roots (17 and 19 bit stages) and the
// dividers (17 bit stages). Synchronous active-low reset empties the pipeline.
module fresnel_reflectance_unit
    import fru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int S_W  = FRAC_W;
    localparam int M_W  = NW_W;
    localparam int N2_W = 2 * NW_W;
    localparam int Q_W  = FRAC_W;

    // Early verdict for zero and negative index, carried down the pipe.
    typedef struct packed {
        logic              spec;
        logic [FRAC_W-1:0] spec_r;
        logic              spec_tir;
    } t_spec;

    typedef struct packed {
        logic [FRAC_W-1:0] cw;
        logic [NW_W-1:0]   nw;
        t_spec             sp;
    } t_side_s;

    typedef struct packed {
        logic [FRAC_W-1:0] cw;
        logic [N2_W-1:0]   nw2;
        t_spec             sp;
        logic              tir;
    } t_side_m;

    typedef struct packed {
        t_spec sp;
        logic  tir;
        logic  dz;
    } t_side_d;

    logic en;

    // Stage 1
    logic              r1_vld;
    logic [FRAC_W-1:0] r1_cw;
    logic [NW_W-1:0]   r1_nw;
    logic [2*FRAC_W-1:0] r1_cw2;
    t_spec             r1_sp;
    logic [FRAC_W-1:0] n1_cw;
    t_spec             n1_sp;
    logic [FRAC_W+IDX_SHIFT-1:0] mir_mag;

    // Square root of 1 - c^2
    logic              s_vld;
    logic [S_W-1:0]    s_root;
    t_side_s           s_side;

    // Stage 2
    logic              r2_vld;
    t_side_m           r2_side;
    logic [N2_W-1:0]   r2_rad;

    // Square root of n^2 - s^2
    logic              m_vld;
    logic [M_W-1:0]    m_root;
    t_side_m           m_side;

    // Stages 3 to 5
    logic              r3_vld;
    logic [FRAC_W-1:0] r3_cw;
    logic [M_W-1:0]    r3_m;
    logic [N2_W+FRAC_W-1:0] r3_p;
    t_spec             r3_sp;
    logic              r3_tir;

    logic [21:0]       n2c;
    logic              r4_vld;
    logic [18:0]       r4_num1;
    logic [19:0]       r4_den1;
    logic [21:0]       r4_num2;
    logic [22:0]       r4_den2;
    t_side_d           r4_side;
    logic [18:0]       n4_num1;
    logic [19:0]       n4_den1;
    logic [21:0]       n4_num2;
    logic [22:0]       n4_den2;

    logic              r5_vld;
    logic [37:0]       r5_n1sq;
    logic [39:0]       r5_d1sq;
    logic [43:0]       r5_n2sq;
    logic [45:0]       r5_d2sq;
    t_side_d           r5_side;

    logic              d_vld;
    logic [Q_W-1:0]    d_rs;
    logic [Q_W-1:0]    d_rp;
    t_side_d           d_side;

    logic              r_out_vld;
    t_out_beat         r_out;
    t_out_beat         n_out;
    logic [Q_W:0]      rsum;
    logic [FRAC_W-1:0] rw;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: clamp the cosine, classify the index, square the cosine.
    always_comb begin
        n1_cw   = (i_in_data.cos_incidence > ONE) ? ONE : i_in_data.cos_incidence;
        mir_mag = (FRAC_W+IDX_SHIFT)'(ONE - {1'b0, i_in_data.rel_index}) << IDX_SHIFT;
        n1_sp   = '0;
        if (i_in_data.rel_index == '0) begin
            n1_sp.spec     = 1'b1;
            n1_sp.spec_r   = ONE;
            n1_sp.spec_tir = 1'b1;
        end else if (i_in_data.rel_index[IDX_W-1]) begin
            n1_sp.spec   = 1'b1;
            n1_sp.spec_r = (mir_mag > (FRAC_W+IDX_SHIFT)'(ONE)) ? ONE : mir_mag[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cw  <= n1_cw;
            r1_nw  <= NW_W'({i_in_data.rel_index[IDX_W-2:0], IDX_SHIFT'(0)});
            r1_cw2 <= n1_cw * n1_cw;
            r1_sp  <= n1_sp;
        end
    end

    fru_sqrt_pipe #(
        .RAD_W  (2 * WORK_BITS + 1),
        .ROOT_W (S_W),
        .SIDE_W ($bits(t_side_s))
    ) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r1_vld),
        .i_rad   ((2*WORK_BITS+1)'((2*FRAC_W)'(1) << (2*WORK_BITS)) -
                  (2*WORK_BITS+1)'(r1_cw2)),
        .i_side  ({r1_cw, r1_nw, r1_sp}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Stage 2: squares of s and n, total internal reflection test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side.cw  <= s_side.cw;
            r2_side.nw2 <= s_side.nw * s_side.nw;
            r2_side.sp  <= s_side.sp;
            r2_side.tir <= NW_W'(s_root) > s_side.nw;
            r2_rad      <= (NW_W'(s_root) > s_side.nw) ? '0 :
                           (s_side.nw * s_side.nw) - (N2_W'(s_root) * N2_W'(s_root));
        end
    end

    fru_sqrt_pipe #(
        .RAD_W  (N2_W),
        .ROOT_W (M_W),
        .SIDE_W ($bits(t_side_m))
    ) u_sqrt_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_vld),
        .i_rad   (r2_rad),
        .i_side  (r2_side),
        .o_vld   (m_vld),
        .o_root  (m_root),
        .o_side  (m_side)
    );

    // Stage 3: n^2 * c, scaled down by 2^32 in the next stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= m_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    assign n2c = r3_p[2*WORK_BITS +: 22];

    // Stage 4: magnitudes of the differences and the two denominators.
    always_comb begin
        n4_num1 = (19'(r3_cw) >= r3_m) ? 19'(r3_cw) - r3_m : r3_m - 19'(r3_cw);
        n4_num2 = (22'(r3_m) >= n2c) ? 22'(r3_m) - n2c : n2c - 22'(r3_m);
        n4_den1 = 20'(r3_cw) + 20'(r3_m);
        n4_den2 = 23'(r3_m) + 23'(n2c);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cw   <= m_side.cw;
            r3_m    <= m_root;
            r3_p    <= m_side.nw2 * m_side.cw;
            r3_sp   <= m_side.sp;
            r3_tir  <= m_side.tir;

            r4_num1 <= n4_num1;
            r4_num2 <= n4_num2;
            r4_den1 <= n4_den1;
            r4_den2 <= n4_den2;
            r4_side <= '{sp: r3_sp, tir: r3_tir, dz: (n4_den1 == '0) || (n4_den2 == '0)};

            r5_n1sq <= r4_num1 * r4_num1;
            r5_d1sq <= r4_den1 * r4_den1;
            r5_n2sq <= r4_num2 * r4_num2;
            r5_d2sq <= r4_den2 * r4_den2;
            r5_side <= r4_side;
        end
    end

    fru_div_pipe #(
        .NUM_W  (60),
        .DEN_W  (46),
        .Q_W    (Q_W),
        .SIDE_W ($bits(t_side_d))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_num_a (60'({r5_n1sq, WORK_BITS'(0)})),
        .i_den_a (46'(r5_d1sq)),
        .i_num_b ({r5_n2sq, WORK_BITS'(0)}),
        .i_den_b (r5_d2sq),
        .i_side  (r5_side),
        .o_vld   (d_vld),
        .o_quo_a (d_rs),
        .o_quo_b (d_rp),
        .o_side  (d_side)
    );

    // Final selection: early verdicts win, then total reflection, then a
    // zero denominator, otherwise the mean of the two ratios, clamped to one.
    always_comb begin
        rsum = (Q_W+1)'(d_rs) + (Q_W+1)'(d_rp);
        rw   = (rsum[Q_W:1] > ONE) ? ONE : rsum[Q_W:1];
        n_out.total_reflection = d_side.sp.spec ? d_side.sp.spec_tir : d_side.tir;
        if (d_side.sp.spec) begin
            n_out.reflectance = d_side.sp.spec_r;
        end else if (d_side.tir || d_side.dz) begin
            n_out.reflectance = ONE;
        end else begin
            n_out.reflectance = rw;
        end
        n_out.transmittance = ONE - n_out.reflectance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_tir_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.total_reflection |-> o_out_data.reflectance == ONE)
        else $error("total reflection beat without full reflectance");

    a_sum_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.reflectance <= ONE) &&
            ((FRAC_W+1)'(o_out_data.reflectance) + (FRAC_W+1)'(o_out_data.transmittance)
             == (FRAC_W+1)'(ONE)))
        else $error("reflectance and transmittance do not sum to one");

    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

[rtl/core/fru_sqrt_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_sqrt_pipe
// Pipelined floor integer square root, one result bit per register stage,
// with a sideband word and a valid bit travelling alongside.
// ----------------------------------------------------------------------------
module fru_sqrt_pipe
    import fru_pkg::*;
#(
    parameter int RAD_W  = 33,
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int TW = 2 * ROOT_W + 2;

    logic [ROOT_W-1:0] r_vld;
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [RAD_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // Stage j settles root bit ROOT_W-1-j; the remainder holds v - q^2.
    always_comb begin : p_step
        logic [RAD_W-1:0]  rin;
        logic [ROOT_W-1:0] qin;
        logic [TW-1:0]     trial;
        for (int j = 0; j < ROOT_W; j++) begin
            if (j == 0) begin
                rin = i_rad;
                qin = '0;
            end else begin
                rin = r_rem[j-1];
                qin = r_root[j-1];
            end
            trial = (TW'(qin) << (ROOT_W - j)) + (TW'(1) << (2 * (ROOT_W - 1 - j)));
            if (TW'(rin) >= trial) begin
                n_rem[j]  = RAD_W'(TW'(rin) - trial);
                n_root[j] = qin | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end else begin
                n_rem[j]  = rin;
                n_root[j] = qin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < ROOT_W; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

[rtl/core/fru_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_div_pipe
// Two restoring dividers side by side, one quotient bit per register stage.
// Quotients are known to stay below 2^Q_W.
// ----------------------------------------------------------------------------
module fru_div_pipe
    import fru_pkg::*;
#(
    parameter int NUM_W  = 60,
    parameter int DEN_W  = 46,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num_a,
    input  logic [DEN_W-1:0]  i_den_a,
    input  logic [NUM_W-1:0]  i_num_b,
    input  logic [DEN_W-1:0]  i_den_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo_a,
    output logic [Q_W-1:0]    o_quo_b,
    output logic [SIDE_W-1:0] o_side
);

    localparam int W = DEN_W + Q_W;

    logic [Q_W-1:0]    r_vld;
    logic [W-1:0]      r_rem_a [Q_W];
    logic [W-1:0]      r_rem_b [Q_W];
    logic [DEN_W-1:0]  r_den_a [Q_W];
    logic [DEN_W-1:0]  r_den_b [Q_W];
    logic [Q_W-1:0]    r_quo_a [Q_W];
    logic [Q_W-1:0]    r_quo_b [Q_W];
    logic [SIDE_W-1:0] r_side  [Q_W];
    logic [W-1:0]      n_rem_a [Q_W];
    logic [W-1:0]      n_rem_b [Q_W];
    logic [Q_W-1:0]    n_quo_a [Q_W];
    logic [Q_W-1:0]    n_quo_b [Q_W];

    always_comb begin : p_step
        logic [W-1:0]     ra;
        logic [W-1:0]     rb;
        logic [DEN_W-1:0] da;
        logic [DEN_W-1:0] db;
        logic [Q_W-1:0]   qa;
        logic [Q_W-1:0]   qb;
        logic [W-1:0]     sa;
        logic [W-1:0]     sb;
        for (int j = 0; j < Q_W; j++) begin
            if (j == 0) begin
                ra = W'(i_num_a);
                rb = W'(i_num_b);
                da = i_den_a;
                db = i_den_b;
                qa = '0;
                qb = '0;
            end else begin
                ra = r_rem_a[j-1];
                rb = r_rem_b[j-1];
                da = r_den_a[j-1];
                db = r_den_b[j-1];
                qa = r_quo_a[j-1];
                qb = r_quo_b[j-1];
            end
            sa = W'(da) << (Q_W - 1 - j);
            sb = W'(db) << (Q_W - 1 - j);
            if (ra >= sa) begin
                n_rem_a[j] = ra - sa;
                n_quo_a[j] = qa | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
                n_rem_a[j] = ra;
                n_quo_a[j] = qa;
            end
            if (rb >= sb) begin
                n_rem_b[j] = rb - sb;
                n_quo_b[j] = qb | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
                n_rem_b[j] = rb;
                n_quo_b[j] = qb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_rem_a[j] <= n_rem_a[j];
                r_rem_b[j] <= n_rem_b[j];
                r_quo_a[j] <= n_quo_a[j];
                r_quo_b[j] <= n_quo_b[j];
                r_den_a[j] <= (j == 0) ? i_den_a : r_den_a[j-1];
                r_den_b[j] <= (j == 0) ? i_den_b : r_den_b[j-1];
                r_side[j]  <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_vld   = r_vld[Q_W-1];
    assign o_quo_a = r_quo_a[Q_W-1];
    assign o_quo_b = r_quo_b[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule
